// ----- rtl/pslm_pkg.sv -----
package pslm_pkg;

    localparam int SRC_W     = 6;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int DST_W     = 7;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WARM_UP      = 1'd0;
    localparam t_cfg_idx REG_RESET_OFFSET = 1'd1;

    typedef struct packed {
        logic [TIME_W-1:0] arrive_cycle;
        logic [SRC_W-1:0]  source_node;
        logic              is_head;
        logic [TIME_W-1:0] injection_time;
    } t_in;

    typedef struct packed {
        logic              accepted;
        logic              new_source;
        logic [CNT_W-1:0]  source_flits;
        logic [CNT_W-1:0]  source_packets;
        logic [SUM_W-1:0]  source_delay_sum;
        logic [TIME_W-1:0] source_max_delay;
        logic [TIME_W-1:0] source_last_time;
        logic [CNT_W-1:0]  total_flits;
        logic [CNT_W-1:0]  total_packets;
        logic [SUM_W-1:0]  total_delay_sum;
        logic [TIME_W-1:0] global_max_delay;
        logic [DST_W-1:0]  distinct_sources;
    } t_out;

    // one per-source table entry; the seen bit lives in flops beside the memory
    typedef struct packed {
        logic [CNT_W-1:0]  flits;
        logic [CNT_W-1:0]  packets;
        logic [SUM_W-1:0]  delay_sum;
        logic [TIME_W-1:0] delay_max;
        logic [TIME_W-1:0] last_time;
    } t_entry;

endpackage

// ----- rtl/per_source_flit_latency_monitor.sv -----
// Per-source flit latency monitor. Raise start with a flit word on i_in; busy stays low, so
// a word can be given every cycle. The result is driven on o_out with o_valid high for exactly
// one cycle, from the output register that follows the accept-stage registers; results come
// in order, one per word, and the receiver cannot stall them. The per-source table is read at
// the accept edge, and the update stage then feeds the output register, with the previous write
// forwarded when two consecutive words come from the same source. Table entries read as zero
// until their source is first counted, tracked by a seen flop per source, so no clearing pass
// follows reset. Write the warm-up and reset-offset registers only while no word is in flight.
module per_source_flit_latency_monitor #(
    parameter int NODE_COUNT = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pslm_pkg::t_in                       i_in,
    output logic                                o_valid,
    output pslm_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  pslm_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [pslm_pkg::CFG_W-1:0]          i_cfg_data
);
    import pslm_pkg::*;

    localparam int DEPTH  = (NODE_COUNT < (1 << SRC_W)) ? NODE_COUNT : (1 << SRC_W);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW     = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam logic [63:0] MASK64 = (64'd1 << TW) - 64'd1;
    localparam logic [TIME_W-1:0] TIME_MASK = MASK64[TIME_W-1:0];

    // configuration
    logic [TIME_W-1:0] r_warm_up;
    logic [TIME_W-1:0] r_reset_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_up      <= '0;
            r_reset_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WARM_UP:      r_warm_up      <= i_cfg_data[TIME_W-1:0];
                REG_RESET_OFFSET: r_reset_offset <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    // accept stage
    logic              take;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] inj;
    logic [TIME_W-1:0] since_rst;
    logic              src_ok;
    logic              in_window;
    logic [TIME_W-1:0] lat;
    logic [ADDR_W-1:0] rd_addr;

    always_comb begin
        take      = start && !busy;
        arr       = i_in.arrive_cycle & TIME_MASK;
        inj       = i_in.injection_time & TIME_MASK;
        since_rst = arr - r_reset_offset;
        src_ok    = {1'b0, i_in.source_node} < (SRC_W+1)'(DEPTH);
        in_window = (arr >= r_reset_offset) && (since_rst >= r_warm_up);
        lat       = (arr > inj) ? (arr - inj) : '0;
        rd_addr   = ADDR_W'(i_in.source_node);
    end

    logic              r_s1_vld;
    logic              r_s1_acc;
    logic              r_s1_head;
    logic              r_s1_src_ok;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [TIME_W-1:0] r_s1_lat;
    logic [TIME_W-1:0] r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_acc    <= src_ok && in_window;
            r_s1_head   <= i_in.is_head;
            r_s1_src_ok <= src_ok;
            r_s1_addr   <= rd_addr;
            r_s1_lat    <= lat;
            r_s1_last   <= arr - r_warm_up;
        end
    end

    // per-source table
    t_entry            r_mem [DEPTH];
    t_entry            r_rd_data;
    logic [DEPTH-1:0]  r_seen;
    logic              r_fwd_vld;
    logic [ADDR_W-1:0] r_fwd_addr;
    t_entry            r_fwd_entry;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // global totals
    logic [CNT_W-1:0]  r_all_flits;
    logic [CNT_W-1:0]  r_all_packets;
    logic [SUM_W-1:0]  r_all_sum;
    logic [TIME_W-1:0] r_all_max;
    logic [DST_W-1:0]  r_src_total;

    // update stage
    t_entry            cur;
    t_entry            nxt;
    logic              wr;
    logic              seen_cur;
    logic              fresh;
    logic [SUM_W:0]    src_sum;
    logic [SUM_W:0]    all_sum;
    logic [CNT_W-1:0]  n_all_flits;
    logic [CNT_W-1:0]  n_all_packets;
    logic [SUM_W-1:0]  n_all_sum;
    logic [TIME_W-1:0] n_all_max;
    logic [DST_W-1:0]  n_src_total;
    t_out              n_out;

    always_comb begin
        seen_cur = r_seen[r_s1_addr];
        // the word just ahead wrote this entry at the edge our read happened
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur = r_fwd_entry;
        end else begin
            cur = r_rd_data;
        end
        if (!seen_cur) begin
            cur = '0;
        end

        wr    = r_s1_vld && r_s1_acc;
        fresh = wr && !seen_cur;

        src_sum = {1'b0, cur.delay_sum} + (SUM_W+1)'(r_s1_lat);
        all_sum = {1'b0, r_all_sum} + (SUM_W+1)'(r_s1_lat);

        nxt           = cur;
        n_all_flits   = r_all_flits;
        n_all_packets = r_all_packets;
        n_all_sum     = r_all_sum;
        n_all_max     = r_all_max;
        n_src_total   = r_src_total;

        if (r_s1_acc) begin
            if (!seen_cur && (r_src_total != '1)) begin
                n_src_total = r_src_total + 1'b1;
            end
            if (r_s1_head) begin
                nxt.packets   = (cur.packets == '1) ? cur.packets : cur.packets + 1'b1;
                n_all_packets = (r_all_packets == '1) ? r_all_packets : r_all_packets + 1'b1;
                nxt.delay_sum = src_sum[SUM_W] ? '1 : src_sum[SUM_W-1:0];
                n_all_sum     = all_sum[SUM_W] ? '1 : all_sum[SUM_W-1:0];
                if (r_s1_lat > cur.delay_max) begin
                    nxt.delay_max = r_s1_lat;
                end
                if (r_s1_lat > r_all_max) begin
                    n_all_max = r_s1_lat;
                end
            end
            nxt.flits     = (cur.flits == '1) ? cur.flits : cur.flits + 1'b1;
            n_all_flits   = (r_all_flits == '1) ? r_all_flits : r_all_flits + 1'b1;
            nxt.last_time = r_s1_last;
        end

        n_out = '0;
        n_out.accepted   = r_s1_acc;
        n_out.new_source = fresh;
        if (r_s1_src_ok) begin
            n_out.source_flits     = r_s1_acc ? nxt.flits     : cur.flits;
            n_out.source_packets   = r_s1_acc ? nxt.packets   : cur.packets;
            n_out.source_delay_sum = r_s1_acc ? nxt.delay_sum : cur.delay_sum;
            n_out.source_max_delay = r_s1_acc ? nxt.delay_max : cur.delay_max;
            n_out.source_last_time = r_s1_acc ? nxt.last_time : cur.last_time;
        end
        n_out.total_flits      = n_all_flits;
        n_out.total_packets    = n_all_packets;
        n_out.total_delay_sum  = n_all_sum;
        n_out.global_max_delay = n_all_max;
        n_out.distinct_sources = n_src_total;
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_s1_addr] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr  <= r_s1_addr;
        r_fwd_entry <= nxt;
        if (r_s1_vld) begin
            o_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= '0;
            r_fwd_vld     <= 1'b0;
            o_valid       <= 1'b0;
            r_all_flits   <= '0;
            r_all_packets <= '0;
            r_all_sum     <= '0;
            r_all_max     <= '0;
            r_src_total   <= '0;
        end else begin
            r_fwd_vld <= wr;
            o_valid   <= r_s1_vld;
            if (wr) begin
                r_seen[r_s1_addr] <= 1'b1;
                r_all_flits       <= n_all_flits;
                r_all_packets     <= n_all_packets;
                r_all_sum         <= n_all_sum;
                r_all_max         <= n_all_max;
                r_src_total       <= n_src_total;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_follows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a word two cycles earlier");

    a_new_source_first_flit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.new_source) |->
            (o_out.accepted && (o_out.source_flits == CNT_W'(1))))
        else $error("new source not reported as its first counted flit");

    a_accepted_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.accepted) |->
            ((o_out.source_flits != '0) && (o_out.total_flits >= o_out.source_flits)))
        else $error("counted flit missing from source or total count");

    a_global_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.global_max_delay >= o_out.source_max_delay))
        else $error("source max latency above global max");

    a_distinct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.distinct_sources <= DST_W'(DEPTH)))
        else $error("more distinct sources than table entries");
`endif

endmodule

// ----- verif/tb_per_source_flit_latency_monitor.sv -----
module tb_per_source_flit_latency_monitor;
    import pslm_pkg::*;

    localparam int NODES       = 64;
    localparam int STALL_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in                  i_in;
    logic                 o_valid;
    t_out                 o_out;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    per_source_flit_latency_monitor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the configuration and of the per-source table
    logic [TIME_W-1:0] warm_up_q;
    logic [TIME_W-1:0] offset_q;
    logic              seen_tab    [NODES];
    logic [CNT_W-1:0]  flits_tab   [NODES];
    logic [CNT_W-1:0]  packets_tab [NODES];
    logic [SUM_W-1:0]  dsum_tab    [NODES];
    logic [TIME_W-1:0] dmax_tab    [NODES];
    logic [TIME_W-1:0] last_tab    [NODES];
    logic [CNT_W-1:0]  sum_flits;
    logic [CNT_W-1:0]  sum_packets;
    logic [SUM_W-1:0]  sum_delay;
    logic [TIME_W-1:0] peak_delay;
    logic [DST_W-1:0]  seen_sources;

    t_out pending_stats[$];
    int   error_count;
    int   stall_cycles;
    logic idle_on;
    logic [SRC_W-1:0] prev_src;

    always #10 i_clk = ~i_clk;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a);
        return (a == '1) ? a : a + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [TIME_W-1:0] b);
        logic [SUM_W:0] tmp;
        tmp = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
        return tmp[SUM_W] ? {SUM_W{1'b1}} : tmp[SUM_W-1:0];
    endfunction

    // counts the word against the shadow table and returns the stats it should produce
    function automatic t_out flit_stats_update(t_in w);
        t_out r;
        int s;
        logic take;
        logic fresh;
        logic [TIME_W-1:0] lat;
        s = int'(w.source_node);
        take = (w.arrive_cycle >= offset_q) && ((w.arrive_cycle - offset_q) >= warm_up_q);
        fresh = 1'b0;
        if (take) begin
            if (!seen_tab[s]) begin
                seen_tab[s] = 1'b1;
                fresh = 1'b1;
                if (seen_sources != '1) seen_sources = seen_sources + 1'b1;
            end
            if (w.is_head) begin
                // injection after arrival counts as zero latency
                lat = (w.arrive_cycle > w.injection_time) ?
                      w.arrive_cycle - w.injection_time : '0;
                packets_tab[s] = sat_inc(packets_tab[s]);
                sum_packets = sat_inc(sum_packets);
                dsum_tab[s] = sat_add(dsum_tab[s], lat);
                sum_delay = sat_add(sum_delay, lat);
                if (lat > dmax_tab[s]) dmax_tab[s] = lat;
                if (lat > peak_delay) peak_delay = lat;
            end
            flits_tab[s] = sat_inc(flits_tab[s]);
            sum_flits = sat_inc(sum_flits);
            last_tab[s] = w.arrive_cycle - warm_up_q;
        end
        r.accepted         = take;
        r.new_source       = fresh;
        r.source_flits     = flits_tab[s];
        r.source_packets   = packets_tab[s];
        r.source_delay_sum = dsum_tab[s];
        r.source_max_delay = dmax_tab[s];
        r.source_last_time = last_tab[s];
        r.total_flits      = sum_flits;
        r.total_packets    = sum_packets;
        r.total_delay_sum  = sum_delay;
        r.global_max_delay = peak_delay;
        r.distinct_sources = seen_sources;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        error_count++;
    endtask

    task automatic compare_stats(t_out exp_r, t_out got);
        if (got.accepted !== exp_r.accepted)
            report_mismatch("accepted", 64'(exp_r.accepted), 64'(got.accepted));
        if (got.new_source !== exp_r.new_source)
            report_mismatch("new_source", 64'(exp_r.new_source), 64'(got.new_source));
        if (got.source_flits !== exp_r.source_flits)
            report_mismatch("source_flits", 64'(exp_r.source_flits),
                            64'(got.source_flits));
        if (got.source_packets !== exp_r.source_packets)
            report_mismatch("source_packets", 64'(exp_r.source_packets),
                            64'(got.source_packets));
        if (got.source_delay_sum !== exp_r.source_delay_sum)
            report_mismatch("source_delay_sum", 64'(exp_r.source_delay_sum),
                            64'(got.source_delay_sum));
        if (got.source_max_delay !== exp_r.source_max_delay)
            report_mismatch("source_max_delay", 64'(exp_r.source_max_delay),
                            64'(got.source_max_delay));
        if (got.source_last_time !== exp_r.source_last_time)
            report_mismatch("source_last_time", 64'(exp_r.source_last_time),
                            64'(got.source_last_time));
        if (got.total_flits !== exp_r.total_flits)
            report_mismatch("total_flits", 64'(exp_r.total_flits), 64'(got.total_flits));
        if (got.total_packets !== exp_r.total_packets)
            report_mismatch("total_packets", 64'(exp_r.total_packets),
                            64'(got.total_packets));
        if (got.total_delay_sum !== exp_r.total_delay_sum)
            report_mismatch("total_delay_sum", 64'(exp_r.total_delay_sum),
                            64'(got.total_delay_sum));
        if (got.global_max_delay !== exp_r.global_max_delay)
            report_mismatch("global_max_delay", 64'(exp_r.global_max_delay),
                            64'(got.global_max_delay));
        if (got.distinct_sources !== exp_r.distinct_sources)
            report_mismatch("distinct_sources", 64'(exp_r.distinct_sources),
                            64'(got.distinct_sources));
    endtask

    // result check, prediction at accept, and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_stats.size() == 0)
                    report_mismatch("unexpected result", 64'd0, 64'd1);
                else
                    compare_stats(pending_stats.pop_front(), o_out);
            end
            if (start && !busy)
                pending_stats.insert(pending_stats.size(), flit_stats_update(i_in));
            if ((start && !busy) || o_valid === 1'b1 || i_cfg_we)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_per_source_flit_latency_monitor failed");
                $finish;
            end
        end
    end

    function automatic t_in make_word(logic [TIME_W-1:0] arr, logic [SRC_W-1:0] src,
                                      logic head, logic [TIME_W-1:0] inj);
        t_in w;
        w.arrive_cycle   = arr;
        w.source_node    = src;
        w.is_head        = head;
        w.injection_time = inj;
        return w;
    endfunction

    task automatic send_word(t_in w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_WARM_UP:      warm_up_q = data;
            REG_RESET_OFFSET: offset_q  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(logic [TIME_W-1:0] warm, logic [TIME_W-1:0] offs);
        cfg_write(REG_WARM_UP, warm);
        cfg_write(REG_RESET_OFFSET, offs);
    endtask

    task automatic test_extremes;
        send_word(make_word('0, 6'd0, 1'b1, '0));
        send_word(make_word('1, 6'd63, 1'b1, '0));
        // injection stamp after arrival
        send_word(make_word(32'd5, 6'd63, 1'b1, 32'd10));
        send_word(make_word('1, 6'd63, 1'b0, '1));
        send_word(make_word('1, 6'd0, 1'b1, '1));
        send_word(make_word(32'h8000_0000, 6'd42, 1'b0, 32'h7FFF_FFFF));
        drain();
    endtask

    task automatic test_warm_up_window;
        set_window(32'd500, 32'd1000);
        send_word(make_word(32'd999, 6'd7, 1'b1, 32'd0));
        send_word(make_word(32'd1499, 6'd7, 1'b1, 32'd0));
        send_word(make_word(32'd1500, 6'd7, 1'b1, 32'd1400));
        send_word(make_word('1, 6'd7, 1'b0, 32'd0));
        drain();
        set_window('1, '0);
        send_word(make_word(32'hFFFF_FFFE, 6'd9, 1'b1, 32'd0));
        send_word(make_word('1, 6'd9, 1'b1, 32'd0));
        drain();
        set_window('0, '1);
        send_word(make_word(32'hFFFF_FFFE, 6'd10, 1'b1, 32'd0));
        send_word(make_word('1, 6'd10, 1'b1, 32'd3));
        send_word(make_word(32'd0, 6'd10, 1'b0, 32'd0));
        drain();
    endtask

    task automatic random_traffic(int count);
        logic [TIME_W:0]   edge_t;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] inj;
        logic [SRC_W-1:0]  src;
        int                pick;
        for (int n = 0; n < count; n++) begin
            edge_t = {1'b0, offset_q} + {1'b0, warm_up_q};
            pick = $urandom_range(0, 9);
            if (pick == 0)
                arr = $urandom;
            else if (pick == 1)
                arr = (edge_t > 33'd50) ? edge_t[TIME_W-1:0] - $urandom_range(1, 50)
                                        : $urandom_range(0, 20);
            else begin
                edge_t = edge_t + $urandom_range(0, 100000);
                arr = edge_t[TIME_W] ? $urandom : edge_t[TIME_W-1:0];
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                inj = $urandom;
            else if (pick == 1)
                inj = arr + $urandom_range(1, 100);
            else if (pick == 2)
                inj = '0;
            else
                inj = arr - $urandom_range(0, 200);
            // favor a few busy sources and back-to-back repeats
            pick = $urandom_range(0, 9);
            if (pick < 3)
                src = prev_src;
            else if (pick < 7)
                src = SRC_W'($urandom_range(0, 3));
            else
                src = SRC_W'($urandom_range(0, NODES - 1));
            prev_src = src;
            send_word(make_word(arr, src, 1'($urandom_range(0, 1)), inj));
        end
        drain();
    endtask

    task automatic test_random_windows;
        idle_on = 1'b1;
        set_window('0, '0);
        random_traffic(80);
        set_window($urandom_range(0, 5000), $urandom_range(0, 1000000));
        random_traffic(80);
        set_window(32'h0FFF_0000, 32'hF000_0000);
        random_traffic(80);
        set_window($urandom_range(0, 200), $urandom_range(0, 200));
        random_traffic(80);
    endtask

    task automatic test_back_to_back;
        idle_on = 1'b0;
        set_window(32'd100, 32'd50);
        random_traffic(80);
    endtask

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_WARM_UP;
        i_cfg_data = '0;
        idle_on    = 1'b1;
        prev_src   = '0;
        error_count  = 0;
        stall_cycles = 0;
        warm_up_q  = '0;
        offset_q   = '0;
        for (int k = 0; k < NODES; k++) begin
            seen_tab[k]    = 1'b0;
            flits_tab[k]   = '0;
            packets_tab[k] = '0;
            dsum_tab[k]    = '0;
            dmax_tab[k]    = '0;
            last_tab[k]    = '0;
        end
        sum_flits    = '0;
        sum_packets  = '0;
        sum_delay    = '0;
        peak_delay   = '0;
        seen_sources = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_warm_up_window();
        test_random_windows();
        test_back_to_back();

        if (error_count == 0)
            $display("tb_per_source_flit_latency_monitor passed");
        else
            $display("tb_per_source_flit_latency_monitor failed");
        $finish;
    end

endmodule
